>>> rtl/mfup_pkg.sv
// Shared types, constants and helpers of the motor feedback unwrap and power unit.
`timescale 1ns / 1ps

package mfup_pkg;

	localparam int unsigned DEF_ENCODER_BITS = 13;
	localparam int unsigned NUM_CFG_REGS     = 8;
	localparam int unsigned CFG_IDX_W        = $clog2(NUM_CFG_REGS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POSITION_OFFSET = 3'd0,
		REG_ANGLE_GAIN      = 3'd1,
		REG_SPEED_GAIN      = 3'd2,
		REG_TORQUE_GAIN     = 3'd3,
		REG_COEF_CROSS      = 3'd4,
		REG_COEF_SPEED_SQ   = 3'd5,
		REG_COEF_CURRENT_SQ = 3'd6,
		REG_POWER_BIAS      = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UNWRAP,
		ST_MAC,
		ST_DONE
	} state_t;

	// Order of work on the shared multiplier
	typedef enum logic [3:0] {
		MS_RPM_CUR    = 4'd0,
		MS_CROSS      = 4'd1,
		MS_RPM_SQ     = 4'd2,
		MS_SPEED_SQ   = 4'd3,
		MS_CUR_SQ     = 4'd4,
		MS_CURRENT_SQ = 4'd5,
		MS_ANGLE      = 4'd6,
		MS_SPEED      = 4'd7,
		MS_TORQUE     = 4'd8,
		MS_LAST       = 4'd9
	} mac_step_t;

	localparam logic [15:0] KELVIN_OFFSET_CK = 16'd27315;
	localparam logic [15:0] CENTI_SCALE      = 16'd100;
	localparam logic signed [63:0] Q16_ROUND = 64'sd32768;

	// Round a Q32 value to Q16.16 (ties upward) and saturate to 32 bits
	function automatic logic signed [31:0] q32_to_q16(input logic signed [63:0] v);
		logic signed [63:0] r;
		logic signed [31:0] res;
		r = v + Q16_ROUND;
		if ((r[63:47] == '0) || (r[63:47] == '1)) begin
			res = signed'(r[47:16]);
		end else if (r[63]) begin
			res = 32'sh8000_0000;
		end else begin
			res = 32'sh7FFF_FFFF;
		end
		return res;
	endfunction

endpackage

>>> rtl/motor_feedback_unwrap_power_unit.sv
// Top level: multi-turn unwrap, scaled readings and power estimate of one motor.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready) carries one request: a feedback frame
//   (command 0) or an alive tick (command 1). Output channel (out_valid/out_ready)
//   returns exactly one result per request. The configuration channel
//   (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; write it only
//   while the unit is idle.
// Sequence
//   A frame passes the unwrap state, which updates the turn count, then the
//   single shared 32x32 signed multiplier steps (three power products, three
//   weighted power terms, angle, speed and torque, then the last rounding), then
//   the done state, which hands the result to the output register. The next
//   request is accepted once the unit is back in idle, so a new request is not
//   taken before the last result is handed over. A tick goes straight to done.
// Reset
//   Clears the configuration registers, the turn count, the last position and
//   the alive status (offline), and empties the output register.
// Stall
//   A finished result waits in the output register; the next request is
//   accepted and worked on meanwhile, and only its hand-over waits.
module motor_feedback_unwrap_power_unit
	import mfup_pkg::*;
#(
	parameter int unsigned ENCODER_BITS = DEF_ENCODER_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]               cfg_data,

	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [ENCODER_BITS-1:0]   encoder_position,
	input  logic signed [15:0]        speed_rpm,
	input  logic signed [15:0]        current_raw,
	input  logic [7:0]                temperature_c,

	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      from_frame,
	output logic                      online,
	output logic signed [31:0]        total_count,
	output logic signed [31:0]        angle_rad,
	output logic signed [31:0]        speed_rad_s,
	output logic signed [31:0]        torque_nm,
	output logic signed [31:0]        power_w,
	output logic [15:0]               temperature_centikelvin
);

	localparam int unsigned COUNT_W = 16 + ENCODER_BITS;
	localparam logic signed [ENCODER_BITS:0] HALF_TURN =
		(ENCODER_BITS+1)'(1) << (ENCODER_BITS - 1);

	// Configuration registers
	logic signed [31:0] position_offset_q, angle_gain_q, speed_gain_q, torque_gain_q;
	logic signed [31:0] coef_cross_q, coef_speed_sq_q, coef_current_sq_q, power_bias_q;

	// Unwrap state
	logic [ENCODER_BITS-1:0] last_position_q;
	logic signed [15:0]      turn_count_q;
	logic                    frame_seen_q;
	logic                    alive_q;

	// Request held while it is worked on
	logic [ENCODER_BITS-1:0] pos_q;
	logic signed [15:0]      rpm_q;
	logic signed [15:0]      cur_q;
	logic [7:0]              temp_q;
	logic                    res_frame_q;
	logic                    res_online_q;

	// Sequencer and datapath
	state_t             state_q, state_d;
	mac_step_t          step_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic               acc_en;
	logic signed [31:0] total_q, angle_q, speed_q, torque_q, power_q;
	logic               in_fire, load_out;

	// Unwrap and sum logic
	logic signed [ENCODER_BITS:0] pos_delta;
	logic signed [COUNT_W-1:0]    turn_pos;
	logic signed [33:0]           total_sum;
	logic signed [31:0]           total_sat;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_offset_q <= '0;
			angle_gain_q      <= '0;
			speed_gain_q      <= '0;
			torque_gain_q     <= '0;
			coef_cross_q      <= '0;
			coef_speed_sq_q   <= '0;
			coef_current_sq_q <= '0;
			power_bias_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_POSITION_OFFSET: position_offset_q <= signed'(cfg_data);
				REG_ANGLE_GAIN:      angle_gain_q      <= signed'(cfg_data);
				REG_SPEED_GAIN:      speed_gain_q      <= signed'(cfg_data);
				REG_TORQUE_GAIN:     torque_gain_q     <= signed'(cfg_data);
				REG_COEF_CROSS:      coef_cross_q      <= signed'(cfg_data);
				REG_COEF_SPEED_SQ:   coef_speed_sq_q   <= signed'(cfg_data);
				REG_COEF_CURRENT_SQ: coef_current_sq_q <= signed'(cfg_data);
				REG_POWER_BIAS:      power_bias_q      <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = command ? ST_DONE : ST_UNWRAP;
				end
			end
			ST_UNWRAP: state_d = ST_MAC;
			ST_MAC: begin
				if (step_q == MS_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands, accumulate enable
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		acc_en   = 1'b0;
		mul_a    = 32'(rpm_q);
		mul_b    = 32'(cur_q);
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_UNWRAP: ;
			ST_MAC: begin
				case (step_q)
					MS_RPM_CUR: begin
						mul_a = 32'(rpm_q);
						mul_b = 32'(cur_q);
					end
					MS_CROSS: begin
						mul_a = coef_cross_q;
						mul_b = signed'(prod_q[31:0]);
					end
					MS_RPM_SQ: begin
						mul_a  = 32'(rpm_q);
						mul_b  = 32'(rpm_q);
						acc_en = 1'b1;
					end
					MS_SPEED_SQ: begin
						mul_a = coef_speed_sq_q;
						mul_b = signed'(prod_q[31:0]);
					end
					MS_CUR_SQ: begin
						mul_a  = 32'(cur_q);
						mul_b  = 32'(cur_q);
						acc_en = 1'b1;
					end
					MS_CURRENT_SQ: begin
						mul_a = coef_current_sq_q;
						mul_b = signed'(prod_q[31:0]);
					end
					MS_ANGLE: begin
						mul_a  = total_q;
						mul_b  = angle_gain_q;
						acc_en = 1'b1;
					end
					MS_SPEED: begin
						mul_a = 32'(rpm_q);
						mul_b = speed_gain_q;
					end
					MS_TORQUE: begin
						mul_a = 32'(cur_q);
						mul_b = torque_gain_q;
					end
					MS_LAST: ;
					default: ;
				endcase
			end
			ST_DONE:   load_out = !out_valid || out_ready;
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Wrap detection on the exact difference of positions
	assign pos_delta = signed'({1'b0, pos_q}) - signed'({1'b0, last_position_q});

	// Multi-turn count plus offset, saturated to 32 bits
	assign turn_pos  = signed'({turn_count_q, last_position_q});
	assign total_sum = 34'(turn_pos) + 34'(position_offset_q);
	always_comb begin
		if ((total_sum[33:31] == 3'b000) || (total_sum[33:31] == 3'b111)) begin
			total_sat = signed'(total_sum[31:0]);
		end else if (total_sum[33]) begin
			total_sat = 32'sh8000_0000;
		end else begin
			total_sat = 32'sh7FFF_FFFF;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			step_q          <= MS_RPM_CUR;
			last_position_q <= '0;
			turn_count_q    <= '0;
			frame_seen_q    <= 1'b0;
			alive_q         <= 1'b0;
			out_valid       <= 1'b0;
		end else begin
			state_q <= state_d;

			// Advance through the multiplier steps; restart for the next frame
			if (state_q == ST_MAC && step_q != MS_LAST) begin
				step_q <= mac_step_t'(4'(step_q + 4'd1));
			end else if (state_q != ST_MAC) begin
				step_q <= MS_RPM_CUR;
			end

			if (in_fire) begin
				if (command) begin
					alive_q      <= frame_seen_q;
					frame_seen_q <= 1'b0;
				end else begin
					frame_seen_q <= 1'b1;
				end
			end

			// Step the round counter on a wrap, hold at the 16-bit limits
			if (state_q == ST_UNWRAP) begin
				if (pos_delta < -HALF_TURN) begin
					if (turn_count_q != 16'sh7FFF) begin
						turn_count_q <= turn_count_q + 16'sd1;
					end
				end else if (pos_delta > HALF_TURN) begin
					if (turn_count_q != 16'sh8000) begin
						turn_count_q <= turn_count_q - 16'sd1;
					end
				end
				last_position_q <= pos_q;
			end

			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_q        <= encoder_position;
			rpm_q        <= speed_rpm;
			cur_q        <= current_raw;
			temp_q       <= temperature_c;
			res_frame_q  <= !command;
			res_online_q <= command ? frame_seen_q : alive_q;
		end

		if (state_q == ST_UNWRAP) begin
			acc_q <= 64'(power_bias_q) <<< 16;
		end else if (acc_en) begin
			acc_q <= acc_q + prod_q;
		end

		if (state_q == ST_MAC) begin
			prod_q <= mul_p;
			case (step_q)
				MS_RPM_CUR: total_q  <= total_sat;
				MS_SPEED: begin
					power_q <= q32_to_q16(acc_q);
					angle_q <= q32_to_q16(prod_q);
				end
				MS_TORQUE:  speed_q  <= q32_to_q16(prod_q);
				MS_LAST:    torque_q <= q32_to_q16(prod_q);
				default: ;
			endcase
		end

		// Hand over to the output register; a tick reports zeros
		if (load_out) begin
			from_frame <= res_frame_q;
			online     <= res_online_q;
			if (res_frame_q) begin
				total_count             <= total_q;
				angle_rad               <= angle_q;
				speed_rad_s             <= speed_q;
				torque_nm               <= torque_q;
				power_w                 <= power_q;
				temperature_centikelvin <= 16'(temp_q) * CENTI_SCALE + KELVIN_OFFSET_CK;
			end else begin
				total_count             <= '0;
				angle_rad               <= '0;
				speed_rad_s             <= '0;
				torque_nm               <= '0;
				power_w                 <= '0;
				temperature_centikelvin <= '0;
			end
		end
	end

endmodule
